// File: rtl/nifd_pkg.sv
// Shared types and constants for the NEC infrared frame decoder.
// No dependencies; imported by every module under rtl.
package nifd_pkg;

    localparam int unsigned TimeWidth  = 32;
    localparam int unsigned CodeWidth  = 8;
    localparam int unsigned CountWidth = 6;
    localparam int unsigned CfgIdxWidth = 3;

    localparam logic [CountWidth-1:0] FRAME_BITS = 6'd32;

    typedef enum logic [1:0] {
        OP_EDGE = 2'd0,
        OP_TICK = 2'd1,
        OP_READ = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_READY  = 3'd0,
        ST_START  = 3'd1,
        ST_DATA   = 3'd2,
        ST_WAIT   = 3'd3,
        ST_REPEAT = 3'd4
    } decode_state_t;

    typedef enum logic [CfgIdxWidth-1:0] {
        CFG_DEVICE_ADDRESS = 3'd0,
        CFG_START_GAP_MIN  = 3'd1,
        CFG_START_GAP_MAX  = 3'd2,
        CFG_BIT_THRESHOLD  = 3'd3,
        CFG_REPEAT_GAP_MIN = 3'd4,
        CFG_REPEAT_GAP_MAX = 3'd5,
        CFG_HOLD_DELAY     = 3'd6,
        CFG_IDLE_TIMEOUT   = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [CodeWidth-1:0] device_address;
        logic [TimeWidth-1:0] start_gap_min;
        logic [TimeWidth-1:0] start_gap_max;
        logic [TimeWidth-2:0] bit_threshold;
        logic [TimeWidth-1:0] repeat_gap_min;
        logic [TimeWidth-1:0] repeat_gap_max;
        logic [TimeWidth-1:0] hold_delay;
        logic [TimeWidth-1:0] idle_timeout;
    } cfg_t;

    typedef struct packed {
        logic [1:0]           op;
        logic [TimeWidth-1:0] now_time;
    } request_t;

    typedef struct packed {
        logic                 command_valid;
        logic [CodeWidth-1:0] command_code;
    } result_t;

endpackage

// File: rtl/nifd_cfg_regs.sv
// Configuration register file for the NEC infrared frame decoder.
// Depends on nifd_pkg.
module nifd_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [nifd_pkg::CfgIdxWidth-1:0]    cfg_index,
    input  logic [nifd_pkg::TimeWidth-1:0]      cfg_data,
    output nifd_pkg::cfg_t                      cfg
);
    import nifd_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEVICE_ADDRESS: cfg_next.device_address = cfg_data[CodeWidth-1:0];
                CFG_START_GAP_MIN:  cfg_next.start_gap_min  = cfg_data;
                CFG_START_GAP_MAX:  cfg_next.start_gap_max  = cfg_data;
                CFG_BIT_THRESHOLD:  cfg_next.bit_threshold  = cfg_data[TimeWidth-2:0];
                CFG_REPEAT_GAP_MIN: cfg_next.repeat_gap_min = cfg_data;
                CFG_REPEAT_GAP_MAX: cfg_next.repeat_gap_max = cfg_data;
                CFG_HOLD_DELAY:     cfg_next.hold_delay     = cfg_data;
                CFG_IDLE_TIMEOUT:   cfg_next.idle_timeout   = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/nifd_in_reg.sv
// Input request register of the NEC infrared frame decoder.
// Depends on nifd_pkg.
module nifd_in_reg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [1:0]                      op,
    input  logic [nifd_pkg::TimeWidth-1:0]  now_time,
    input  logic                            take,
    output logic                            req_valid,
    output nifd_pkg::request_t              req
);
    import nifd_pkg::*;

    logic     req_valid_reg;
    logic     req_valid_next;
    request_t req_reg;
    logic     load;

    assign in_ready = !req_valid_reg || take;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (load)
        begin
            req_valid_next = 1'b1;
        end
        else if (take)
        begin
            req_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            req_reg.op       <= op;
            req_reg.now_time <= now_time;
        end
    end

    assign req_valid = req_valid_reg;
    assign req       = req_reg;

endmodule

// File: rtl/nifd_core.sv
// Frame decode state machine, timing checks and pending command store.
// Depends on nifd_pkg.
module nifd_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  nifd_pkg::request_t  req,
    input  nifd_pkg::cfg_t      cfg,
    output nifd_pkg::result_t   result
);
    import nifd_pkg::*;

    decode_state_t         state_reg, state_next;
    logic [TimeWidth-1:0]  last_edge_reg, last_edge_next;
    logic [TimeWidth-1:0]  command_time_reg, command_time_next;
    logic [TimeWidth-1:0]  shift_reg, shift_next;
    logic [CountWidth-1:0] count_reg, count_next;
    logic [CodeWidth-1:0]  pending_code_reg, pending_code_next;
    logic                  pending_valid_reg, pending_valid_next;

    logic [TimeWidth-1:0]  gap;
    logic [TimeWidth-1:0]  hold_gap;
    logic                  start_ok;
    logic                  repeat_ok;
    logic                  too_long;
    logic                  bit_one;
    logic [TimeWidth-1:0]  shifted;
    logic [CountWidth-1:0] count_inc;
    logic                  frame_done;
    logic                  frame_ok;
    logic                  hold_ok;
    logic                  timed_out;

    assign gap        = req.now_time - last_edge_reg;
    assign hold_gap   = req.now_time - command_time_reg;
    assign start_ok   = (cfg.start_gap_min < gap) && (gap < cfg.start_gap_max);
    assign repeat_ok  = (cfg.repeat_gap_min < gap) && (gap < cfg.repeat_gap_max);
    assign too_long   = gap > {cfg.bit_threshold, 1'b0};
    assign bit_one    = gap > {1'b0, cfg.bit_threshold};
    assign shifted    = {shift_reg[TimeWidth-2:0], bit_one};
    assign count_inc  = count_reg + 1'b1;
    assign frame_done = count_inc == FRAME_BITS;
    assign frame_ok   = (shifted[31:24] == cfg.device_address)
                     && (shifted[31:24] == ~shifted[23:16])
                     && (shifted[15:8] == ~shifted[7:0]);
    assign hold_ok    = hold_gap > cfg.hold_delay;
    assign timed_out  = (state_reg != ST_READY) && (gap > cfg.idle_timeout);

    // next state
    always_comb
    begin
        state_next = state_reg;
        if (fire)
        begin
            case (req.op)
                OP_EDGE:
                begin
                    case (state_reg)
                        ST_READY:  state_next = ST_START;
                        ST_START:  state_next = start_ok ? ST_DATA : ST_READY;
                        ST_DATA:
                        begin
                            if (too_long)
                                state_next = ST_READY;
                            else if (frame_done)
                                state_next = frame_ok ? ST_WAIT : ST_READY;
                            else
                                state_next = ST_DATA;
                        end
                        ST_WAIT:   state_next = ST_REPEAT;
                        ST_REPEAT: state_next = repeat_ok ? ST_WAIT : ST_READY;
                        default:   state_next = ST_READY;
                    endcase
                end
                OP_TICK:
                begin
                    if (timed_out)
                        state_next = ST_READY;
                end
                default: state_next = state_reg;
            endcase
        end
    end

    // datapath and result
    always_comb
    begin
        last_edge_next     = last_edge_reg;
        command_time_next  = command_time_reg;
        shift_next         = shift_reg;
        count_next         = count_reg;
        pending_code_next  = pending_code_reg;
        pending_valid_next = pending_valid_reg;
        result             = '0;
        if (fire)
        begin
            case (req.op)
                OP_EDGE:
                begin
                    case (state_reg)
                        ST_READY, ST_WAIT:
                        begin
                            last_edge_next = req.now_time;
                        end
                        ST_START:
                        begin
                            if (start_ok)
                            begin
                                count_next     = '0;
                                last_edge_next = req.now_time;
                            end
                        end
                        ST_DATA:
                        begin
                            if (!too_long)
                            begin
                                shift_next = shifted;
                                count_next = count_inc;
                                if (!frame_done)
                                begin
                                    last_edge_next = req.now_time;
                                end
                                else if (frame_ok)
                                begin
                                    pending_code_next  = shifted[15:8];
                                    pending_valid_next = 1'b1;
                                    last_edge_next     = req.now_time;
                                    command_time_next  = req.now_time;
                                end
                            end
                        end
                        ST_REPEAT:
                        begin
                            if (repeat_ok)
                            begin
                                last_edge_next = req.now_time;
                                if (hold_ok)
                                begin
                                    pending_code_next  = shift_reg[15:8];
                                    pending_valid_next = 1'b1;
                                end
                            end
                        end
                        default: last_edge_next = last_edge_reg;
                    endcase
                end
                OP_READ:
                begin
                    result.command_valid = pending_valid_reg;
                    result.command_code  = pending_valid_reg ? pending_code_reg : '0;
                    pending_valid_next   = 1'b0;
                end
                default: result = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_READY;
            last_edge_reg     <= '0;
            command_time_reg  <= '0;
            shift_reg         <= '0;
            count_reg         <= '0;
            pending_code_reg  <= '0;
            pending_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            last_edge_reg     <= last_edge_next;
            command_time_reg  <= command_time_next;
            shift_reg         <= shift_next;
            count_reg         <= count_next;
            pending_code_reg  <= pending_code_next;
            pending_valid_reg <= pending_valid_next;
        end
    end

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FRAME_BITS)
        else $error("bit count above frame length");

    a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (req.op == OP_READ) |=> !pending_valid_reg)
        else $error("pending command not cleared by read");

    a_data_entry: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (state_reg == ST_START) && (state_next == ST_DATA) |=> count_reg == '0)
        else $error("bit count not cleared on frame start");

    a_wait_has_command: assert property (@(posedge clk) disable iff (!rst_n)
        fire && (state_reg == ST_DATA) && (state_next == ST_WAIT) |=> pending_valid_reg)
        else $error("frame accepted without pending command");

endmodule

// File: rtl/nifd_out_reg.sv
// Result register of the NEC infrared frame decoder.
// Depends on nifd_pkg.
module nifd_out_reg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  nifd_pkg::result_t                   result,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                command_valid,
    output logic [nifd_pkg::CodeWidth-1:0]      command_code
);
    import nifd_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t result_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign command_valid = result_reg.command_valid;
    assign command_code  = result_reg.command_code;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ready |-> !load)
        else $error("result overwritten while stalled");

endmodule

// File: rtl/nec_ir_frame_decoder_top.sv
// Top level of the NEC infrared frame decoder.
// Depends on nifd_pkg, nifd_cfg_regs, nifd_in_reg, nifd_core, nifd_out_reg.
//
//   channel   direction  handshake            payload
//   request   in         in_valid / in_ready  op, now_time
//   result    out        out_valid/out_ready  command_valid, command_code
//   config    in         cfg_we               cfg_index, cfg_data
//
// One request per cycle while the result side is not stalled; a request passes through
// the input register, then the decode logic, then the result register.
// Reset clears the decoder state, the pending command and all config registers.
// A stalled result holds the input register; once both are full in_ready drops.
module nec_ir_frame_decoder_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          op,
    input  logic [nifd_pkg::TimeWidth-1:0]      now_time,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                command_valid,
    output logic [nifd_pkg::CodeWidth-1:0]      command_code,
    input  logic                                cfg_we,
    input  logic [nifd_pkg::CfgIdxWidth-1:0]    cfg_index,
    input  logic [nifd_pkg::TimeWidth-1:0]      cfg_data
);
    import nifd_pkg::*;

    cfg_t     cfg;
    request_t req;
    result_t  result;
    logic     req_valid;
    logic     res_free;
    logic     fire;

    assign res_free = !out_valid || out_ready;
    assign fire     = req_valid && res_free;

    nifd_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    nifd_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .now_time  (now_time),
        .take      (fire),
        .req_valid (req_valid),
        .req       (req)
    );

    nifd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .req    (req),
        .cfg    (cfg),
        .result (result)
    );

    nifd_out_reg u_out_reg (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (fire),
        .result        (result),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .command_valid (command_valid),
        .command_code  (command_code)
    );

endmodule
